// File: rtl/assert_macros.svh
// assertion macros shared by the sorted set table rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sst_pkg.sv
// types, codes and sizing constants for the sorted set table
// no dependencies; imported by every rtl module of the block
package sst_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [CNT_W-1:0]       t_count;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        t_command    command;
        logic [31:0] element_value;
    } t_cmd_item;

    typedef struct packed {
        t_status    status;
        logic [8:0] position;
        logic [8:0] entry_count;
    } t_result;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic cmp;
        logic shift_up;
        logic shift_down;
    } t_cell_ctl;

    // external 32-bit value folded into the stored width
    function automatic t_value to_value(logic [31:0] x);
        logic [VALUE_WIDTH+31:0] tmp;
        tmp = {{VALUE_WIDTH{1'b0}}, x};
        return tmp[VALUE_WIDTH-1:0];
    endfunction

    // count or index folded into the 9-bit result fields
    function automatic logic [8:0] to_nine(t_count x);
        logic [CNT_W+8:0] tmp;
        tmp = {9'b0, x};
        return tmp[8:0];
    endfunction

endpackage

// File: rtl/sorted_set_table_unit.sv
// sorted set table: distinct values kept ascending in a row of cells
// an item passes the cell compare state S_CMP, then the position encode state S_ENC
// over CAPACITY+1 boundary flags, then the result register; a new item is taken
// only when the previous one is done and busy is low
// reset: entry count cleared, state idle; entries stay undefined, no clearing pass
// results are strobed for one cycle and cannot be stalled by the receiver
module sorted_set_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sst_pkg::t_cmd_item i_item,
    output logic               busy,
    output logic               o_strobe,
    output sst_pkg::t_result   o_result
);
    import sst_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_ENC  = 3'b100
    } t_state;

    t_state    r_state, n_state;
    t_count    r_count, n_count;
    t_command  r_cmd;
    t_value    r_key;
    logic      r_strobe;
    t_result   r_result, n_result;

    t_cell_ctl cell_ctl;

    // row wiring
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] lt_left;
    logic [CAPACITY-1:0] valid;
    logic [CAPACITY:0]   edges;
    logic [CAPACITY-1:0] hits;
    t_value              values      [CAPACITY];
    t_value              left_values [CAPACITY];
    t_value              right_values[CAPACITY];

    t_count pos;
    logic   held;
    logic   full;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;
    assign full     = (r_count >= CNT_W'(CAPACITY));

    // the cell row: each cell sees its left neighbor's compare bit and both neighbors' values
    for (genvar g = 0; g < CAPACITY; g++) begin : g_row
        assign valid[g]   = (CNT_W'(g) < r_count);
        assign lt_left[g] = (g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1];
        assign left_values[g]  = (g == 0) ? r_key : values[(g == 0) ? 0 : g - 1];
        assign right_values[g] = (g == CAPACITY - 1) ? values[g]
                               : values[(g == CAPACITY - 1) ? g : g + 1];

        sst_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_valid       (valid[g]),
            .i_key         (r_key),
            .i_lt_left     (lt_left[g]),
            .i_left_value  (left_values[g]),
            .i_right_value (right_values[g]),
            .o_lt          (lt[g]),
            .o_edge        (edges[g]),
            .o_hit         (hits[g]),
            .o_value       (values[g])
        );
    end

    // boundary past the last cell: every slot is held and below the key
    assign edges[CAPACITY] = lt[CAPACITY-1];

    sst_pos_encoder u_enc (
        .i_edge (edges),
        .i_hit  (hits),
        .o_pos  (pos),
        .o_held (held)
    );

    // cells compare in S_CMP, shift on the edge that ends S_ENC
    always_comb begin
        cell_ctl.cmp        = (r_state == S_CMP);
        cell_ctl.shift_up   = (r_state == S_ENC) && (r_cmd == CMD_INSERT) && !held && !full;
        cell_ctl.shift_down = (r_state == S_ENC) && (r_cmd == CMD_REMOVE) && held;
    end

    // result and new count, decided from the encoded position
    always_comb begin
        n_count            = r_count;
        n_result.status    = ST_DONE;
        n_result.position  = to_nine(pos);
        case (r_cmd)
            CMD_CLEAR: begin
                n_count           = '0;
                n_result.position = '0;
            end
            CMD_INSERT: begin
                if (held) begin
                    n_result.status = ST_MISS;
                end else if (full) begin
                    n_result.status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (held) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_result.status = ST_MISS;
                end
            end
            default: begin
                // find
                if (!held) begin
                    n_result.status = ST_MISS;
                end
            end
        endcase
        n_result.entry_count = to_nine(n_count);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_ENC;
            end
            S_ENC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_ENC);
            if (r_state == S_ENC) begin
                r_count <= n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd <= i_item.command;
            r_key <= to_value(i_item.element_value);
        end
        if (r_state == S_ENC) begin
            r_result <= n_result;
        end
    end

    // sorted row gives a thermometer compare vector, so one boundary exactly
    `ASSERT_IMPL(a_one_boundary, i_clk, i_rst_n, r_state == S_ENC, $onehot(edges),
        "cell row not sorted: boundary flags not one-hot")
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY),
        "entry count beyond capacity")
    `ASSERT_IMPL(a_strobe_after_enc, i_clk, i_rst_n, o_strobe, $past(r_state == S_ENC),
        "result strobe without an encode cycle")
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_strobe,
        "accepted item did not occupy the block")

endmodule

// File: rtl/sst_cell.sv
// one storage cell of the sorted row: holds an entry, compares, shifts
// depends on sst_pkg
module sst_cell (
    input  logic              i_clk,
    input  sst_pkg::t_cell_ctl i_ctl,
    input  logic              i_valid,
    input  sst_pkg::t_value   i_key,
    input  logic              i_lt_left,
    input  sst_pkg::t_value   i_left_value,
    input  sst_pkg::t_value   i_right_value,
    output logic              o_lt,
    output logic              o_edge,
    output logic              o_hit,
    output sst_pkg::t_value   o_value
);
    import sst_pkg::*;

    t_value r_value;
    logic   r_lt;
    logic   r_eq;

    // first cell not below the key
    assign o_edge  = i_lt_left & ~r_lt;
    assign o_hit   = o_edge & r_eq;
    assign o_lt    = r_lt;
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= i_valid && (r_value < i_key);
            r_eq <= i_valid && (r_value == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_up) begin
            if (o_edge) begin
                r_value <= i_key;
            end else if (!r_lt) begin
                r_value <= i_left_value;
            end
        end else if (i_ctl.shift_down) begin
            if (!r_lt) begin
                r_value <= i_right_value;
            end
        end
    end

endmodule

// File: rtl/sst_pos_encoder.sv
// turns the one-hot boundary flags of the cell row into a position
// depends on sst_pkg
module sst_pos_encoder (
    input  logic [sst_pkg::CAPACITY:0]   i_edge,
    input  logic [sst_pkg::CAPACITY-1:0] i_hit,
    output sst_pkg::t_count              o_pos,
    output logic                         o_held
);
    import sst_pkg::*;

    always_comb begin
        o_pos = '0;
        for (int i = 0; i <= CAPACITY; i++) begin
            if (i_edge[i]) begin
                o_pos = o_pos | CNT_W'(i);
            end
        end
    end

    assign o_held = |i_hit;

endmodule

// File: tb/sorted_set_table_unit_test.sv
// self-checking testbench for the sorted set table: commands go in through start/busy,
// results come back on a one-cycle strobe and are checked against a built-in set predictor
// depends on rtl/sst_pkg.sv and rtl/sorted_set_table_unit.sv
module sorted_set_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    logic      i_clk;
    logic      i_rst_n  = 1'b0;
    logic      start    = 1'b0;
    t_cmd_item cmd_item = '0;
    logic      busy;
    logic      o_strobe;
    t_result   o_result;

    sorted_set_table_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (cmd_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // predictor copy of the set: ascending values, only the first held_count are live
    t_value  held_values[CAPACITY];
    int      held_count = 0;

    // results still owed by the block, oldest first
    t_result pending_results[$];
    t_result oldest_result;

    int      mismatch_count = 0;
    // sender idles in random bursts while this is set
    bit      gaps_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // apply one command to the predicted set and return the result it should give
    function automatic t_result apply_set_command(t_command c, logic [31:0] raw);
        t_value  v;
        int      slot;
        bit      held;
        t_result r;
        v = t_value'(raw);
        slot = 0;
        r.status = ST_DONE;
        if (c == CMD_CLEAR) begin
            held_count = 0;
        end else begin
            // slot = number of held values below v
            while (slot < held_count && held_values[slot] < v) slot++;
            held = (slot < held_count) && (held_values[slot] == v);
            case (c)
                CMD_INSERT: begin
                    // duplicate check wins over the full check
                    if (held) begin
                        r.status = ST_MISS;
                    end else if (held_count >= CAPACITY) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = held_count; i > slot; i--)
                            held_values[i] = held_values[i-1];
                        held_values[slot] = v;
                        held_count++;
                    end
                end
                CMD_REMOVE: begin
                    if (held) begin
                        for (int i = slot; i + 1 < held_count; i++)
                            held_values[i] = held_values[i+1];
                        held_count--;
                    end else begin
                        r.status = ST_MISS;
                    end
                end
                default: begin
                    if (!held) r.status = ST_MISS;
                end
            endcase
        end
        r.position    = 9'(slot);
        r.entry_count = 9'(held_count);
        return r;
    endfunction

    // value picker: mostly values near the live set so hits and neighbors are common
    function automatic logic [31:0] pick_value();
        int sel;
        int idx;
        sel = $urandom_range(0, 9);
        if (held_count > 0 && sel <= 3) begin
            idx = $urandom_range(0, held_count - 1);
            return 32'(held_values[idx]);
        end else if (held_count > 0 && sel == 4) begin
            idx = $urandom_range(0, held_count - 1);
            return 32'(held_values[idx]) + ($urandom_range(0, 1) ? 32'd1 : -32'd1);
        end else if (sel == 5) begin
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hFFFF_FFFE;
                default: return 32'hFFFF_FFFF;
            endcase
        end else if (sel == 6) begin
            return 32'($urandom_range(0, 63));
        end
        return $urandom;
    endfunction

    // true when v sits in the predicted set; leaves the set untouched
    function automatic bit apply_probe(logic [31:0] v);
        for (int i = 0; i < held_count; i++)
            if (held_values[i] == t_value'(v)) return 1'b1;
        return 1'b0;
    endfunction

    // present one item, wait for the block to take it, then log what it should answer
    task automatic send_command(t_command c, logic [31:0] v);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_item <= '{command: c, element_value: v};
        start    <= 1'b1;
        @(posedge i_clk);
        // accepted at the first edge where busy was low
        while (busy) @(posedge i_clk);
        pending_results.push_back(apply_set_command(c, v));
    endtask

    task automatic wait_for_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_results.size() != 0 && waited < 10_000) begin
            @(posedge i_clk);
            waited++;
        end
        // wait on in case a stray strobe follows
        repeat (8) @(posedge i_clk);
    endtask

    // every result is checked at the edge that ends its strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, entry_count",
                                o_result.entry_count, 0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_result.status !== oldest_result.status)
                    report_mismatch("status", o_result.status, oldest_result.status);
                if (o_result.position !== oldest_result.position)
                    report_mismatch("position", o_result.position, oldest_result.position);
                if (o_result.entry_count !== oldest_result.entry_count)
                    report_mismatch("entry_count", o_result.entry_count,
                                    oldest_result.entry_count);
            end
        end
    end

    // extremes of the value field, each command, duplicate and absent cases, clear
    task automatic test_directed_cases();
        send_command(CMD_FIND,   32'h0000_0000);   // find on empty set
        send_command(CMD_REMOVE, 32'hFFFF_FFFF);   // remove from empty set
        send_command(CMD_CLEAR,  32'h0000_0000);   // clear of empty set
        send_command(CMD_INSERT, 32'h8000_0000);
        send_command(CMD_INSERT, 32'h0000_0000);   // goes in at the bottom
        send_command(CMD_INSERT, 32'hFFFF_FFFF);   // goes in at the top
        send_command(CMD_INSERT, 32'h0000_0000);   // already held
        send_command(CMD_INSERT, 32'h7FFF_FFFF);   // lands in the middle
        send_command(CMD_FIND,   32'h0000_0000);
        send_command(CMD_FIND,   32'hFFFF_FFFF);
        send_command(CMD_FIND,   32'h0000_0005);   // absent, reports slot it would take
        send_command(CMD_REMOVE, 32'h7FFF_FFFF);
        send_command(CMD_REMOVE, 32'h7FFF_FFFF);   // gone already
        send_command(CMD_FIND,   32'h8000_0000);
        send_command(CMD_INSERT, 32'hAAAA_AAAA);
        send_command(CMD_INSERT, 32'h5555_5555);
        send_command(CMD_REMOVE, 32'h0000_0000);   // remove the lowest entry
        send_command(CMD_REMOVE, 32'hFFFF_FFFF);   // remove the highest entry
        send_command(CMD_CLEAR,  32'h1234_5678);
        send_command(CMD_FIND,   32'hAAAA_AAAA);   // nothing held after clear
        send_command(CMD_INSERT, 32'h0000_0001);
        send_command(CMD_REMOVE, 32'h0000_0001);
        wait_for_results();
    endtask

    // fill to capacity, then hit the full store with new, held and lookup items
    task automatic test_full_store();
        logic [31:0] spare;
        int          guard;
        guard = 0;
        send_command(CMD_CLEAR, $urandom);
        while (held_count < CAPACITY && guard < 4 * CAPACITY) begin
            send_command(CMD_INSERT, $urandom);
            guard++;
        end
        // find a value that is not held for the overflow insert
        spare = $urandom;
        while (apply_probe(spare)) spare = $urandom;
        send_command(CMD_INSERT, spare);                           // store full
        send_command(CMD_INSERT, 32'(held_values[0]));             // held beats full
        send_command(CMD_INSERT, 32'(held_values[CAPACITY-1]));
        send_command(CMD_FIND,   32'(held_values[CAPACITY-1]));    // top slot
        send_command(CMD_FIND,   spare);
        send_command(CMD_REMOVE, 32'(held_values[CAPACITY/2]));
        send_command(CMD_INSERT, spare);                           // room again
        send_command(CMD_INSERT, ~spare);
        send_command(CMD_REMOVE, 32'(held_values[0]));
        send_command(CMD_REMOVE, 32'(held_values[held_count-1]));
        send_command(CMD_CLEAR,  32'h0);
        wait_for_results();
    endtask

    // random command mix weighted toward inserts so the set grows between clears
    task automatic test_random_mix(int n_items);
        int       sel;
        t_command c;
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)      c = CMD_INSERT;
            else if (sel < 67) c = CMD_REMOVE;
            else if (sel < 97) c = CMD_FIND;
            else               c = CMD_CLEAR;
            send_command(c, pick_value());
        end
        wait_for_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_full_store();
        test_random_mix(100);
        // closing stretch at full rate, no sender gaps
        gaps_on = 1'b0;
        test_random_mix(60);

        if (pending_results.size() != 0)
            report_mismatch("results never delivered", pending_results.size(), 0);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
